// File: design/assert_macros.svh
// Assertion macros shared by the gaussian blur RTL.
// No dependencies; the bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// File: design/gbc_pkg.sv
// Package for the gaussian blur unit: defaults, register codes and the
// control bundle passed from the line store stage to the window stage.
package gbc_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int PIXEL_BITS_DEF = 8;
    localparam int FIFO_DEPTH     = 8;

    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 16;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 16;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd480;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IDX_WIDTH  = 1'b0,
        CFG_IDX_HEIGHT = 1'b1
    } cfg_index_t;

    typedef enum logic {
        MODE_PIXEL = 1'b0,
        MODE_DRAIN = 1'b1
    } item_mode_t;

    typedef struct packed {
        logic valid;     // window shifts in a new column
        logic col_zero;  // first column: replicate left edge
        logic emit_a;    // centered result for the previous column
        logic emit_b;    // row end result, right edge replicated
        logic last;      // final result of the image
    } win_ctrl_t;

endpackage

// File: design/gbc_line_ram.sv
// Simple dual port line store, one write and one registered read port.
// No dependencies.
module gbc_line_ram #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/gbc_window.sv
// 3x3 window registers and the 1-2-1 weighted sum with shift by four.
// Depends on gbc_pkg for the control bundle.
module gbc_window #(
    parameter int PIXEL_BITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  gbc_pkg::win_ctrl_t    ctrl,
    input  logic [PIXEL_BITS-1:0] col_top,
    input  logic [PIXEL_BITS-1:0] col_mid,
    input  logic [PIXEL_BITS-1:0] col_bot,
    output logic [1:0]            res_count,
    output logic [PIXEL_BITS:0]   res0,       // {last, value}
    output logic [PIXEL_BITS:0]   res1        // {last, value}
);

    localparam int SUM_W = PIXEL_BITS + 4;

    logic [PIXEL_BITS-1:0] win_reg  [3][3];
    logic [PIXEL_BITS-1:0] win_next [3][3];
    logic [PIXEL_BITS-1:0] col_in   [3];
    logic                  emit_a_reg, emit_a_next;
    logic                  emit_b_reg, emit_b_next;
    logic                  last_reg, last_next;
    logic [SUM_W-1:0]      h_a [3];
    logic [SUM_W-1:0]      h_b [3];
    logic [SUM_W-1:0]      sum_a, sum_b;
    logic [PIXEL_BITS-1:0] blur_a, blur_b;

    assign col_in[0] = col_top;
    assign col_in[1] = col_mid;
    assign col_in[2] = col_bot;

    always_comb begin
        win_next = win_reg;
        if (ctrl.valid) begin
            for (int k = 0; k < 3; k++) begin
                if (ctrl.col_zero) begin
                    win_next[k][0] = col_in[k];
                    win_next[k][1] = col_in[k];
                end else begin
                    win_next[k][0] = win_reg[k][1];
                    win_next[k][1] = win_reg[k][2];
                end
                win_next[k][2] = col_in[k];
            end
        end
        emit_a_next = ctrl.valid & ctrl.emit_a;
        emit_b_next = ctrl.valid & ctrl.emit_b;
        last_next   = ctrl.valid & ctrl.emit_b & ctrl.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    win_reg[k][j] <= '0;
                end
            end
            emit_a_reg <= 1'b0;
            emit_b_reg <= 1'b0;
            last_reg   <= 1'b0;
        end else begin
            win_reg    <= win_next;
            emit_a_reg <= emit_a_next;
            emit_b_reg <= emit_b_next;
            last_reg   <= last_next;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            h_a[k] = SUM_W'(win_reg[k][0]) + (SUM_W'(win_reg[k][1]) << 1)
                   + SUM_W'(win_reg[k][2]);
            h_b[k] = SUM_W'(win_reg[k][1]) + (SUM_W'(win_reg[k][2]) << 1)
                   + SUM_W'(win_reg[k][2]);
        end
        sum_a  = h_a[0] + (h_a[1] << 1) + h_a[2];
        sum_b  = h_b[0] + (h_b[1] << 1) + h_b[2];
        blur_a = sum_a[SUM_W-1:4];
        blur_b = sum_b[SUM_W-1:4];
    end

    assign res_count = {1'b0, emit_a_reg} + {1'b0, emit_b_reg};
    assign res0 = emit_a_reg ? {1'b0, blur_a} : {last_reg, blur_b};
    assign res1 = {last_reg, blur_b};

endmodule

// File: design/gbc_out_fifo.sv
// Result queue taking up to two entries per cycle and giving one.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module gbc_out_fifo #(
    parameter int DEPTH  = 8,
    parameter int DATA_W = 9
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        push_count,
    input  logic [DATA_W-1:0] push_data0,
    input  logic [DATA_W-1:0] push_data1,
    input  logic              pop,
    output logic              out_valid,
    output logic [DATA_W-1:0] out_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PTR_W-1:0]  wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push_count) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            mem[wr_ptr_reg] <= push_data0;
        end
        if (push_count == 2'd2) begin
            mem[wr_ptr_plus1] <= push_data1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];

    `ASSERT_NEVER(fifo_overflow, aclk, aresetn, (32'(count_reg) + 32'(push_count)) > DEPTH)
    `ASSERT_IMPLIES(pop_needs_data, aclk, aresetn, pop, count_reg != '0)

endmodule

// File: design/gaussian_blur_3x3_clamped_unit.sv
// 3x3 gaussian blur, replicate border: top level with the column and row
// counters, the shared line store, the window stage and the result queue.
// Depends on gbc_pkg, gbc_line_ram, gbc_window, gbc_out_fifo, assert_macros.svh.
//
// Usage:
//   s_ channel: one pixel request per cycle, tdata = pixel_value, tuser = mode
//   (0 pixel, 1 drain). After the last pixel of an image send image_width
//   drain requests to flush the final row; pixel requests while draining and
//   drain requests while pixels are expected are taken and dropped.
//   m_ channel: tdata = filtered value, tlast marks the final pixel of an image.
//   cfg channel: index 0 = image_width, 1 = image_height; always ready.
//   Path: a result passes the s1 registers, the window registers and the queue before m_tvalid rises.
//   Throughput: one request per cycle while s_tready is high; output row r leaves while row r+1
//   enters, two results at each row end (one at width 1), none at row start.
//   The line store is read per request and written back per kept request; a
//   request on the same entry as the one before gets the written data forwarded.
//   Stall: the 8-entry result queue holds results; s_tready drops once seven
//   results are outstanding, so nothing is lost while m_tready is low.
//   Reset: counters, window and queue clear; registers return to 640 x 480.
//   The line store is not cleared; the first row fills it.
`include "assert_macros.svh"

module gaussian_blur_3x3_clamped_unit #(
    parameter int MAX_WIDTH  = gbc_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = gbc_pkg::PIXEL_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((PIXEL_BITS+7)/8)*8-1:0]     s_tdata,   // pixel_value
    input  logic                                s_tuser,   // mode
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((PIXEL_BITS+7)/8)*8-1:0]     m_tdata,   // filtered_value
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gbc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [gbc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int TDATA_W = ((PIXEL_BITS + 7) / 8) * 8;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int CMP_W   = (COL_W + 1 > gbc_pkg::WIDTH_REG_W) ? COL_W + 1
                                                                : gbc_pkg::WIDTH_REG_W;
    localparam int ROW_W   = gbc_pkg::HEIGHT_REG_W;
    localparam int RES_W   = PIXEL_BITS + 1;
    localparam int CRED_W  = $clog2(gbc_pkg::FIFO_DEPTH + 1);

    logic [gbc_pkg::WIDTH_REG_W-1:0]  width_reg, width_next;
    logic [gbc_pkg::HEIGHT_REG_W-1:0] height_reg, height_next;
    logic [COL_W-1:0]                 col_reg, col_next;
    logic [ROW_W-1:0]                 row_reg, row_next;
    logic [CRED_W-1:0]                credit_reg, credit_next;

    logic [CMP_W-1:0]                 width_ext, width_eff, col_plus1;
    logic [ROW_W-1:0]                 height_eff;
    logic                             draining, row_end, row_first;
    logic                             accept, item_ok, pop;
    logic [1:0]                       n_emit;
    gbc_pkg::item_mode_t              mode;

    gbc_pkg::win_ctrl_t               s1_win_reg, s1_win_next;
    logic                             s1_wr_reg, s1_first_reg, s1_drain_reg;
    logic [COL_W-1:0]                 s1_addr_reg;
    logic [PIXEL_BITS-1:0]            s1_pix_reg;
    logic                             fwd_reg, fwd_next;
    logic [2*PIXEL_BITS-1:0]          fwd_data_reg;

    logic [2*PIXEL_BITS-1:0]          ram_rd, rows_rd, wr_data;
    logic [PIXEL_BITS-1:0]            px_top, px_mid, px_bot;

    logic [1:0]                       res_count;
    logic [RES_W-1:0]                 res0, res1, fifo_out;

    // configuration
    assign cfg_ready = 1'b1;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid) begin
            case (gbc_pkg::cfg_index_t'(cfg_index))
                gbc_pkg::CFG_IDX_WIDTH: begin
                    width_next = cfg_data[gbc_pkg::WIDTH_REG_W-1:0];
                end
                gbc_pkg::CFG_IDX_HEIGHT: begin
                    height_next = cfg_data[gbc_pkg::HEIGHT_REG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // request decode and counters
    always_comb begin
        width_ext = CMP_W'(width_reg);
        if (width_ext == '0) begin
            width_eff = CMP_W'(1);
        end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
            width_eff = CMP_W'(MAX_WIDTH);
        end else begin
            width_eff = width_ext;
        end
        col_plus1  = CMP_W'(col_reg) + CMP_W'(1);
        row_end    = (col_plus1 >= width_eff);
        height_eff = (height_reg == '0) ? ROW_W'(1) : height_reg;
        draining   = (row_reg >= height_eff);
        row_first  = (row_reg == '0);

        mode    = gbc_pkg::item_mode_t'(s_tuser);
        accept  = s_tvalid & s_tready;
        item_ok = accept & ((mode == gbc_pkg::MODE_DRAIN) == draining);

        s1_win_next.valid    = item_ok & ~row_first;
        s1_win_next.col_zero = (col_reg == '0);
        s1_win_next.emit_a   = ~row_first & (col_reg != '0);
        s1_win_next.emit_b   = ~row_first & row_end;
        s1_win_next.last     = draining & row_end;

        n_emit = s1_win_next.valid ? ({1'b0, s1_win_next.emit_a} + {1'b0, s1_win_next.emit_b})
                                   : 2'd0;

        col_next = col_reg;
        row_next = row_reg;
        if (item_ok) begin
            if (row_end) begin
                col_next = '0;
                row_next = draining ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end

        pop         = m_tvalid & m_tready;
        credit_next = credit_reg + CRED_W'(n_emit) - CRED_W'(pop);
    end

    assign s_tready = (32'(credit_reg) <= gbc_pkg::FIFO_DEPTH - 2);

    // line store read-modify-write; entry = {upper, middle}
    gbc_line_ram #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (2 * PIXEL_BITS)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (s1_wr_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_data),
        .rd_addr (col_reg),
        .rd_data (ram_rd)
    );

    always_comb begin
        rows_rd = fwd_reg ? fwd_data_reg : ram_rd;
        px_top  = rows_rd[2*PIXEL_BITS-1:PIXEL_BITS];
        px_mid  = rows_rd[PIXEL_BITS-1:0];
        px_bot  = s1_drain_reg ? px_mid : s1_pix_reg;
        wr_data = s1_first_reg ? {s1_pix_reg, s1_pix_reg} : {px_mid, px_bot};
        fwd_next = s1_wr_reg & (s1_addr_reg == col_reg);
    end

    always_ff @(posedge aclk) begin
        s1_addr_reg  <= col_reg;
        s1_pix_reg   <= s_tdata[PIXEL_BITS-1:0];
        s1_first_reg <= row_first;
        s1_drain_reg <= draining;
        fwd_data_reg <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= gbc_pkg::WIDTH_RESET;
            height_reg <= gbc_pkg::HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
            credit_reg <= '0;
            s1_win_reg <= '0;
            s1_wr_reg  <= 1'b0;
            fwd_reg    <= 1'b0;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            credit_reg <= credit_next;
            s1_win_reg <= s1_win_next;
            s1_wr_reg  <= item_ok;
            fwd_reg    <= fwd_next;
        end
    end

    gbc_window #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (s1_win_reg),
        .col_top   (px_top),
        .col_mid   (px_mid),
        .col_bot   (px_bot),
        .res_count (res_count),
        .res0      (res0),
        .res1      (res1)
    );

    gbc_out_fifo #(
        .DEPTH  (gbc_pkg::FIFO_DEPTH),
        .DATA_W (RES_W)
    ) u_out_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (res_count),
        .push_data0 (res0),
        .push_data1 (res1),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_data   (fifo_out)
    );

    assign m_tdata = TDATA_W'(fifo_out[PIXEL_BITS-1:0]);
    assign m_tlast = fifo_out[PIXEL_BITS];

    `ASSERT_NEVER(credit_bound, aclk, aresetn, 32'(credit_reg) > gbc_pkg::FIFO_DEPTH)
    `ASSERT_IMPLIES(win_needs_write, aclk, aresetn, s1_win_reg.valid, s1_wr_reg && !s1_first_reg)
    `ASSERT_IMPLIES(last_at_row_end, aclk, aresetn, s1_win_reg.valid && s1_win_reg.last, s1_win_reg.emit_b)

endmodule
